// File: design/hrd_pkg.sv
package hrd_pkg;

  // payload widths
  localparam int IR_W      = 16;
  localparam int TIME_W    = 32;
  localparam int AC_W      = 18;
  localparam int BPM_W     = 16;
  localparam int SAMPLE_W  = 17;
  localparam int DC_W      = 31;
  localparam int FIR_ACC_W = 33;
  localparam int PROD_W    = 32;
  localparam int COEF_W    = 13;
  localparam int SWING_W   = 19;
  localparam int BEAT_W    = 4;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam int MIN_SWING_W = 16;
  localparam int MAX_SWING_W = 18;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SWING  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SWING  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BEATS_PER  = 2'd2;

  localparam logic [MIN_SWING_W-1:0] MIN_SWING_RST = 16'd20;
  localparam logic [MAX_SWING_W-1:0] MAX_SWING_RST = 18'd1000;
  localparam logic [BEAT_W-1:0]      BEATS_PER_RST = 4'd5;

  // delay line
  localparam int HRD_LINE_DEPTH = 32;
  localparam int TAP_IDX_W  = 4;
  localparam int TAP_BACK_W = 5;
  localparam logic [TAP_IDX_W-1:0]  CENTRE_TAP = 4'd11;
  localparam logic [TAP_BACK_W-1:0] LAST_BACK  = 5'd22;

  // rate division
  localparam int NUM_W     = 20;
  localparam int N_W       = 5;
  localparam int BPM_SCALE = 60000;
  localparam int STEP_W    = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DC,
    ST_FIR,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   done;
    logic signed [AC_W-1:0] ac;
  } fir_res_t;

  // half of the symmetric low-pass kernel, outer tap first
  function automatic logic [COEF_W-1:0] fir_coef(input logic [TAP_IDX_W-1:0] k);
    logic [COEF_W-1:0] c;
    case (k)
      4'd0:    c = 13'd172;
      4'd1:    c = 13'd321;
      4'd2:    c = 13'd579;
      4'd3:    c = 13'd927;
      4'd4:    c = 13'd1360;
      4'd5:    c = 13'd1858;
      4'd6:    c = 13'd2390;
      4'd7:    c = 13'd2916;
      4'd8:    c = 13'd3391;
      4'd9:    c = 13'd3768;
      4'd10:   c = 13'd4012;
      4'd11:   c = 13'd4096;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: design/hrd_line_mem.sv
module hrd_line_mem
  import hrd_pkg::*;
#(
  parameter int  DEPTH = HRD_LINE_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr_a,
  input  logic [AW-1:0]              rd_addr_b,
  output logic signed [SAMPLE_W-1:0] rd_data_a,
  output logic signed [SAMPLE_W-1:0] rd_data_b
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld_r;
  logic signed [SAMPLE_W-1:0] q_a_r;
  logic signed [SAMPLE_W-1:0] q_b_r;
  logic                       vld_a_r;
  logic                       vld_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a_r <= mem[rd_addr_a];
    q_b_r <= mem[rd_addr_b];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? q_a_r : '0;
  assign rd_data_b = vld_b_r ? q_b_r : '0;

endmodule

// File: design/hrd_fir.sv
module hrd_fir
  import hrd_pkg::*;
#(
  parameter int LINE_DEPTH = HRD_LINE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  output fir_res_t                   res
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int SW = AW + 2;

  logic [AW-1:0]               wp_r;
  logic                        iss_r;
  logic [TAP_IDX_W-1:0]        k_r;
  logic                        rd_v_r;
  logic [TAP_IDX_W-1:0]        rd_k_r;
  logic                        prod_v_r;
  logic                        prod_last_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [FIR_ACC_W-1:0] acc_r;
  logic                        done_r;

  logic [AW-1:0]               addr_a;
  logic [AW-1:0]               addr_b;
  logic signed [SAMPLE_W-1:0]  rd_a;
  logic signed [SAMPLE_W-1:0]  rd_b;
  logic signed [AC_W-1:0]      pair;
  logic signed [COEF_W:0]      coef_s;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic [AW-1:0]               wp_nxt;

  // address of the sample taken 'back' items ago
  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                             input logic [TAP_BACK_W-1:0] back);
    logic [SW-1:0] s;
    s = {2'b00, wp} + SW'(LINE_DEPTH) - SW'(back);
    if (s >= SW'(LINE_DEPTH)) begin
      s = s - SW'(LINE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign addr_a = tap_addr(wp_r, TAP_BACK_W'(k_r));
  assign addr_b = tap_addr(wp_r, LAST_BACK - TAP_BACK_W'(k_r));
  assign wp_nxt = (wp_r == AW'(LINE_DEPTH - 1)) ? '0 : wp_r + 1'b1;

  hrd_line_mem #(
    .DEPTH (LINE_DEPTH)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (start),
    .wr_addr   (wp_r),
    .wr_data   (sample),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // the centre tap has no partner
  always_comb begin
    if (rd_k_r == CENTRE_TAP) begin
      pair = AC_W'(rd_a);
    end else begin
      pair = AC_W'(rd_a) + AC_W'(rd_b);
    end
    coef_s   = $signed({1'b0, fir_coef(rd_k_r)});
    prod_nxt = pair * coef_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      iss_r       <= 1'b0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      rd_k_r      <= '0;
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      acc_r       <= '0;
      done_r      <= 1'b0;
    end else begin
      rd_v_r      <= iss_r;
      rd_k_r      <= k_r;
      prod_v_r    <= rd_v_r;
      prod_last_r <= rd_v_r && (rd_k_r == CENTRE_TAP);
      done_r      <= prod_v_r && prod_last_r;
      if (start) begin
        iss_r <= 1'b1;
        k_r   <= '0;
        acc_r <= '0;
      end else if (iss_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == CENTRE_TAP) begin
          iss_r <= 1'b0;
        end
      end
      if (prod_v_r) begin
        acc_r <= acc_r + FIR_ACC_W'(prod_r);
        if (prod_last_r) begin
          wp_r <= wp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign res.done = done_r;
  assign res.ac   = acc_r[FIR_ACC_W-1:FIR_ACC_W-AC_W];

endmodule

// File: design/hrd_div.sv
module hrd_div
  import hrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  logic [TIME_W-1:0] rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [TIME_W-1:0] den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [TIME_W:0]   trial;
  logic              fits;

  // one quotient bit a cycle, restoring
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? TIME_W'(trial - {1'b0, den_r}) : trial[TIME_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: design/ppg_heartbeat_rate_detector.sv
// PPG heart-rate detector.
// Input channel in_*: one IR sample and its millisecond timestamp per transfer.
// Result channel out_*: exactly one result per input transfer, in order: the
// filtered AC value, a beat flag, and a rate in beats per minute when the
// configured number of beats has been seen (bpm is 0 otherwise).
// cfg_*: write-only registers min_swing, max_swing and beats_per_result,
// written while no sample is in flight.
// One sample is worked on at a time, so a new sample is not taken until the
// result of the last one has been loaded into the result register. The
// processing time is set by the 12 paired reads of the delay-line memory
// feeding one shared multiply-accumulate, plus the 20-step serial divider
// when the sample completes a rate result.
// The result register lets the next sample enter while a result waits; if
// the receiver stalls longer, the next result holds until out_tready.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// DC estimate, the detector and the delay line (through per-entry valid bits,
// no clearing pass), and the block is ready as soon as reset is released.
module ppg_heartbeat_rate_detector
  import hrd_pkg::*;
#(
  parameter int LINE_DEPTH = HRD_LINE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ir_sample[15:0], time_ms[47:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // filtered_ac[17:0], beat[18],
                                            // bpm_valid[19], bpm[35:20], zero
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [MIN_SWING_W-1:0] min_swing_r;
  logic [MAX_SWING_W-1:0] max_swing_r;
  logic [BEAT_W-1:0]      beats_per_r;

  logic [IR_W-1:0]         x_r;
  logic [TIME_W-1:0]       t_r;
  logic [TIME_W-1:0]       ref_time_r;
  logic                    have_ref_r;
  logic [DC_W-1:0]         dc_accum_r;

  logic signed [AC_W-1:0]  prev_ac_r;
  logic signed [AC_W-1:0]  smax_r;
  logic signed [AC_W-1:0]  smin_r;
  logic                    rise_r;
  logic                    fall_r;
  logic [BEAT_W-1:0]       beat_total_r;

  logic signed [AC_W-1:0]  res_ac_r;
  logic                    res_beat_r;
  logic                    res_valid_r;
  logic [BPM_W-1:0]        res_bpm_r;

  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic                    in_xfer;
  logic                    fir_start;
  logic                    div_start;
  logic                    out_load;

  logic signed [FIR_ACC_W-1:0] dc_diff;
  logic signed [FIR_ACC_W-1:0] dc_sum;
  logic [IR_W-1:0]             dc_val;
  logic signed [SAMPLE_W-1:0]  sample;
  fir_res_t                    fir_res;

  logic signed [AC_W-1:0]  cur;
  logic signed [SWING_W:0] swing;
  logic                    beat;
  logic                    fire;
  logic                    rise_n;
  logic                    fall_n;
  logic signed [AC_W-1:0]  smax_n;
  logic signed [AC_W-1:0]  smin_n;
  logic [BEAT_W-1:0]       bt_n;
  logic [N_W-1:0]          n_beats;
  logic [NUM_W-1:0]        div_num;
  logic [TIME_W-1:0]       elapsed;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fir_start = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DC;
        end
      end
      ST_DC: begin
        fir_start = 1'b1;
        state_nxt = ST_FIR;
      end
      ST_FIR: begin
        if (fir_res.done) begin
          if (fire && (elapsed != '0)) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_swing_r <= MIN_SWING_RST;
      max_swing_r <= MAX_SWING_RST;
      beats_per_r <= BEATS_PER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MIN_SWING: min_swing_r <= cfg_wdata[MIN_SWING_W-1:0];
        REG_MAX_SWING: max_swing_r <= cfg_wdata[MAX_SWING_W-1:0];
        REG_BEATS_PER: beats_per_r <= cfg_wdata[BEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ DC removal
  always_comb begin
    dc_diff = $signed({2'b00, x_r, 15'd0}) - $signed({2'b00, dc_accum_r});
    dc_sum  = $signed({2'b00, dc_accum_r}) + (dc_diff >>> 4);
    dc_val  = dc_sum[DC_W-1:DC_W-IR_W];
    sample  = $signed({1'b0, x_r}) - $signed({1'b0, dc_val});
  end

  hrd_fir #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_fir (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (fir_start),
    .sample (sample),
    .res    (fir_res)
  );

  // --------------------------------------------------------- beat detection
  always_comb begin
    cur    = fir_res.ac;
    rise_n = rise_r;
    fall_n = fall_r;
    smax_n = smax_r;
    smin_n = smin_r;
    beat   = 1'b0;
    swing  = (SWING_W + 1)'(smax_r) - (SWING_W + 1)'(smin_r);
    if (prev_ac_r < 0 && cur >= 0) begin
      rise_n = 1'b1;
      fall_n = 1'b0;
      smax_n = '0;
      beat   = (swing > $signed({4'd0, min_swing_r})) &&
               (swing < $signed({2'd0, max_swing_r}));
    end else if (prev_ac_r > 0 && cur <= 0) begin
      rise_n = 1'b0;
      fall_n = 1'b1;
      smin_n = '0;
    end
    if (rise_n && cur > prev_ac_r) begin
      smax_n = cur;
    end else if (fall_n && cur < prev_ac_r) begin
      smin_n = cur;
    end
    bt_n    = beat ? beat_total_r + 1'b1 : beat_total_r;
    fire    = beat && (bt_n == beats_per_r);
    n_beats = (beats_per_r == '0) ? N_W'(16) : {1'b0, beats_per_r};
    div_num = NUM_W'(BPM_SCALE * n_beats);
    elapsed = t_r - ref_time_r;
  end

  hrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (elapsed),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= in_tdata[IR_W-1:0];
      t_r <= in_tdata[IR_W +: TIME_W];
      if (!have_ref_r) begin
        ref_time_r <= in_tdata[IR_W +: TIME_W];
      end
    end
    if ((state_r == ST_FIR) && fir_res.done) begin
      res_ac_r    <= cur;
      res_beat_r  <= beat;
      res_valid_r <= fire;
      res_bpm_r   <= fire ? '1 : '0;
    end else if ((state_r == ST_DIV) && div_done) begin
      res_bpm_r <= (|div_quo[NUM_W-1:BPM_W]) ? '1 : div_quo[BPM_W-1:0];
    end
    if (out_load) begin
      out_tdata_r <= {{(OUT_DATA_W - AC_W - 2 - BPM_W){1'b0}},
                      res_bpm_r, res_valid_r, res_beat_r, res_ac_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r   <= 1'b0;
      dc_accum_r   <= '0;
      prev_ac_r    <= '0;
      smax_r       <= '0;
      smin_r       <= '0;
      rise_r       <= 1'b0;
      fall_r       <= 1'b0;
      beat_total_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        have_ref_r <= 1'b1;
      end
      if (state_r == ST_DC) begin
        dc_accum_r <= dc_sum[DC_W-1:0];
      end
      if ((state_r == ST_FIR) && fir_res.done) begin
        if (fire) begin
          // restart the detector; filter state stays
          have_ref_r   <= 1'b0;
          prev_ac_r    <= '0;
          smax_r       <= '0;
          smin_r       <= '0;
          rise_r       <= 1'b0;
          fall_r       <= 1'b0;
          beat_total_r <= '0;
        end else begin
          prev_ac_r    <= cur;
          smax_r       <= smax_n;
          smin_r       <= smin_n;
          rise_r       <= rise_n;
          fall_r       <= fall_n;
          beat_total_r <= bt_n;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ------------------------------------------------------------- assertions
  a_rate_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[AC_W+1] || out_tdata[AC_W]))
    else $error("rate result without a beat");

  a_fir_done_in_fir: assert property (@(posedge clk) disable iff (!rst_n)
    fir_res.done |-> (state_r == ST_FIR))
    else $error("filter finished outside its phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its phase");

  a_ref_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> have_ref_r)
    else $error("reference time not held after an input transfer");

endmodule

// File: verif/ppg_heartbeat_rate_detector_tb.sv
module ppg_heartbeat_rate_detector_tb;
  import hrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1850;
  localparam int SETTLE      = 45;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 1_500_000;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [IR_W-1:0]   ir;
    logic [TIME_W-1:0] tms;
  } sample_t;

  typedef struct packed {
    logic signed [AC_W-1:0] ac;
    logic                   beat;
    logic                   rate_valid;
    logic [BPM_W-1:0]       bpm;
  } beat_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ppg_heartbeat_rate_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  sample_t      samples_q[$];
  beat_report_t beat_reports_q[$];
  int           mismatches = 0;
  int           sent_total = 0;
  int           cycles = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           hold_req = 0;
  int           hold_seen = 0;
  bit           quiet = 1'b0;
  int           level = 0;
  logic [31:0]  t_now = '0;

  // detector model: registers
  int lim_low    = MIN_SWING_RST;
  int lim_high   = MAX_SWING_RST;
  int beats_goal = BEATS_PER_RST;

  // detector model: filter and beat state
  longint      dc_est = 0;
  int          fir_line [HRD_LINE_DEPTH];
  int          fir_wr = 0;
  int          last_ac = 0;
  int          peak_ac = 0;
  int          trough_ac = 0;
  bit          going_up = 1'b0;
  bit          going_down = 1'b0;
  int          beat_cnt = 0;
  logic [31:0] meas_start = '0;
  bit          meas_armed = 1'b0;
  int          lp_kernel [12] = '{172, 321, 579, 927, 1360, 1858, 2390, 2916, 3391,
                                  3768, 4012, 4096};

  initial begin
    for (int i = 0; i < HRD_LINE_DEPTH; i++) fir_line[i] = 0;
  end

  function automatic int line_tap(int back);
    return fir_line[(fir_wr + HRD_LINE_DEPTH - back) % HRD_LINE_DEPTH];
  endfunction

  function automatic beat_report_t detect_sample(logic [IR_W-1:0] ir, logic [TIME_W-1:0] tms);
    beat_report_t r;
    longint       x;
    longint       acc;
    longint       swing;
    longint       q;
    longint       elapsed;
    logic [31:0]  el;
    int           dc;
    int           cur;
    int           prev;
    int           n;
    bit           beat_now;
    r = '0;
    beat_now = 1'b0;
    x = ir;
    if (!meas_armed) begin
      meas_start = tms;
      meas_armed = 1'b1;
    end
    acc = dc_est + ((x * 32768 - dc_est) >>> 4);
    dc_est = acc & 64'h7FFF_FFFF;
    dc = int'(dc_est >> 15);
    fir_line[fir_wr] = int'(x) - dc;
    acc = lp_kernel[11] * longint'(line_tap(11));
    for (int i = 0; i < 11; i++)
      acc += lp_kernel[i] * (longint'(line_tap(i)) + longint'(line_tap(22 - i)));
    fir_wr = (fir_wr + 1) % HRD_LINE_DEPTH;
    cur = int'(acc >>> 15);
    prev = last_ac;
    last_ac = cur;
    if (prev < 0 && cur >= 0) begin
      swing = longint'(peak_ac) - longint'(trough_ac);
      going_up = 1'b1;
      going_down = 1'b0;
      peak_ac = 0;
      if (swing > lim_low && swing < lim_high) beat_now = 1'b1;
    end else if (prev > 0 && cur <= 0) begin
      going_up = 1'b0;
      going_down = 1'b1;
      trough_ac = 0;
    end
    if (going_up && cur > prev) peak_ac = cur;
    else if (going_down && cur < prev) trough_ac = cur;
    r.ac = cur[AC_W-1:0];
    r.beat = beat_now;
    if (beat_now) begin
      beat_cnt = (beat_cnt + 1) & 15;
      if (beat_cnt == beats_goal) begin
        n = (beats_goal != 0) ? beats_goal : 16;
        el = tms - meas_start;
        elapsed = {32'd0, el};
        q = (elapsed != 0) ? (longint'(BPM_SCALE) * n) / elapsed : 65535;
        if (q > 65535) q = 65535;
        r.bpm = q[BPM_W-1:0];
        r.rate_valid = 1'b1;
        // restart beat counting, keep the filter history
        last_ac = 0;
        peak_ac = 0;
        trough_ac = 0;
        going_up = 1'b0;
        going_down = 1'b0;
        beat_cnt = 0;
        meas_armed = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic flag_mismatch(string field, longint got, longint want);
    if (mismatches < 60)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // sender
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready)
        beat_reports_q.push_back(detect_sample(in_tdata[IR_W-1:0],
                                               in_tdata[IR_W+TIME_W-1:IR_W]));
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (samples_q.size() != 0) begin
          nxt = samples_q.pop_front();
          in_tdata <= {nxt.tms, nxt.ir};
          in_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : check_reports
    beat_report_t want;
    int           g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (beat_reports_q.size() == 0) begin
          flag_mismatch("result with none outstanding", out_tdata[AC_W-1:0], 0);
        end else begin
          want = beat_reports_q.pop_front();
          if (out_tdata[17:0] !== want.ac)
            flag_mismatch("filtered_ac", $signed(out_tdata[17:0]), want.ac);
          if (out_tdata[18] !== want.beat)
            flag_mismatch("beat", out_tdata[18], want.beat);
          if (out_tdata[19] !== want.rate_valid)
            flag_mismatch("bpm_valid", out_tdata[19], want.rate_valid);
          if (out_tdata[35:20] !== want.bpm)
            flag_mismatch("bpm", out_tdata[35:20], want.bpm);
          if (out_tdata[OUT_DATA_W-1:36] !== '0)
            flag_mismatch("padding", out_tdata[OUT_DATA_W-1:36], 0);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        stall_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= (stall_left == 1);
      end else if (out_tvalid && out_tready) begin
        g = pick_gap();
        stall_left <= g;
        out_tready <= (g == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("ppg_heartbeat_rate_detector_tb NOT OK");
      $finish;
    end
  end

  task automatic push_sample(int ir, logic [31:0] tms);
    sample_t s;
    s.ir = ir[IR_W-1:0];
    s.tms = tms;
    samples_q.push_back(s);
    sent_total++;
  endtask

  task automatic advance_time(int tick_pct);
    if (tick_pct >= 100) t_now += $urandom_range(12, 8);
    else if ($urandom_range(99, 0) < tick_pct) t_now += 1;
  endtask

  // pulse-like triangle segments with light jitter, broken up by noise bursts
  task automatic queue_mix(int count, int per_lo, int per_hi, int amp_lo, int amp_hi,
                           int tick_pct);
    int k;
    int per;
    int amp;
    int len;
    int ph;
    int tri_v;
    int jit;
    int x;
    k = 0;
    while (k < count) begin
      if ($urandom_range(99, 0) < 12) begin
        len = $urandom_range(10, 3);
        for (int i = 0; i < len; i++) begin
          advance_time(tick_pct);
          push_sample($urandom_range(65535, 0), t_now);
        end
      end else begin
        per = $urandom_range(per_hi, per_lo);
        amp = $urandom_range(amp_hi, amp_lo);
        // now and then a swing outside the accepted window
        if ($urandom_range(9, 0) == 0)
          amp = ($urandom_range(1, 0) != 0) ? $urandom_range(6, 1) : amp * 8;
        jit = $urandom_range(2, 0);
        len = per * $urandom_range(5, 2);
        for (int i = 0; i < len; i++) begin
          ph = i % per;
          tri_v = (2 * ph < per) ? (4 * amp * ph / per - amp) : (3 * amp - 4 * amp * ph / per);
          x = level + tri_v + $urandom_range(2 * jit, 0) - jit;
          if (x < 0) x = 0;
          if (x > 65535) x = 65535;
          advance_time(tick_pct);
          push_sample(x, t_now);
        end
      end
      k += len;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_q.size() != 0 || in_tvalid || beat_reports_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MIN_SWING: lim_low = val[MIN_SWING_W-1:0];
      REG_MAX_SWING: lim_high = val[MAX_SWING_W-1:0];
      REG_BEATS_PER: beats_goal = val[BEAT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int mn, int mx, int bpr, int count, int per_lo, int per_hi,
                           int amp_lo, int amp_hi, int tick_pct, int base, bit calm);
    logic [CFG_DATA_W-1:0] v;
    wait_drained();
    v = $urandom();
    v[MIN_SWING_W-1:0] = mn;
    set_reg(REG_MIN_SWING, v);
    v = mx;
    set_reg(REG_MAX_SWING, v);
    v = $urandom();
    v[BEAT_W-1:0] = bpr;
    set_reg(REG_BEATS_PER, v);
    @(negedge clk);
    quiet = calm;
    level = base;
    queue_mix(count, per_lo, per_hi, amp_lo, amp_hi, tick_pct);
  endtask

  initial begin : stimulus
    int mn;
    int mx;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // rail-to-rail samples and extreme timestamps on the reset settings
    for (int i = 0; i < 20; i++)
      push_sample((i < 12) ? 65535 : 0,
                  (i % 4 == 0) ? 32'h0000_0000 : (i % 4 == 1) ? 32'hFFFF_FFFF :
                  (i % 4 == 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);

    // reset settings, timestamps wrapping through zero
    wait_drained();
    t_now = 32'hFFFF_FE00;
    level = 30000;
    queue_mix(220, 24, 60, 15, 300, 100);

    // widest window, a rate on every beat
    run_phase(0, 262143, 1, 120, 24, 60, 10, 300, 100, 20000, 1'b1);
    // only huge swings could pass the lower bound
    run_phase(65535, 262143, 3, 100, 30, 60, 5000, 30000, 100, 32768, 1'b0);
    // empty window, nothing counts
    run_phase(10, 0, 2, 60, 24, 60, 15, 300, 100, 20000, 1'b0);
    // time stands still: zero elapsed; receiver holds off meanwhile
    run_phase(20, 1000, 1, 100, 24, 50, 15, 300, 0, 12000, 1'b0);
    @(negedge clk);
    hold_req++;
    // time barely moves: the rate saturates
    run_phase(20, 1000, 4, 130, 24, 40, 15, 300, 2, 12000, 1'b0);
    // lower the beat target below the running count mid-measurement
    run_phase(0, 262143, 12, 150, 20, 40, 15, 300, 100, 25000, 1'b1);
    run_phase(0, 262143, 2, 250, 20, 40, 15, 300, 100, 25000, 1'b0);
    // write to the unused index, then a beat target of zero (sixteen beats)
    wait_drained();
    set_reg(REG_UNUSED, $urandom());
    run_phase(0, 262143, 0, 300, 20, 40, 15, 300, 100, 40000, 1'b0);

    while (sent_total < ITEMS) begin
      mn = ($urandom_range(4, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(200, 0);
      mx = ($urandom_range(4, 0) == 0) ? $urandom_range(262143, 0) : $urandom_range(3000, 100);
      t_now = $urandom();
      run_phase(mn, mx, $urandom_range(15, 0), $urandom_range(200, 100), 20, 60, 10, 400,
                100, $urandom_range(50000, 5000), ($urandom_range(3, 0) == 0));
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("ppg_heartbeat_rate_detector_tb OK");
    end else begin
      $display("ppg_heartbeat_rate_detector_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hrd_pkg.sv
design/hrd_line_mem.sv
design/hrd_fir.sv
design/hrd_div.sv
design/ppg_heartbeat_rate_detector.sv
verif/ppg_heartbeat_rate_detector_tb.sv
